// File: rtl/core/byte_ring_fifo_with_fill_stats_unit_macros.svh
// assertion macros for the byte ring fifo with fill statistics
// used by byte_ring_fifo_with_fill_stats_unit; no other dependencies
`ifndef BYTE_RING_FIFO_WITH_FILL_STATS_UNIT_MACROS_SVH
`define BYTE_RING_FIFO_WITH_FILL_STATS_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/brf_pkg.sv
// shared types and constants for the byte ring fifo with fill statistics
// no dependencies
package brf_pkg;

    localparam int FUNC_W    = 2;
    localparam int DATA_W    = 8;
    localparam int LEN_W     = 13;
    localparam int CNT_W     = 13;
    localparam int PCT_W     = 7;
    localparam int CMP_W     = 17;
    localparam int PROD_W    = 20;
    localparam int REM_W     = 14;
    localparam int DIV_STEPS = 7;
    localparam int STEP_W    = 3;
    localparam int LEN_MAX   = 8191;
    localparam int LEN_RST   = 4096;
    localparam int PCT_SCALE = 100;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_STATUS = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

// File: rtl/core/brf_in_if.sv
// request channel of the byte ring fifo: valid/ready plus operation and byte
// depends on brf_pkg for field widths
interface brf_in_if;
    logic                        valid;
    logic                        ready;
    logic [brf_pkg::FUNC_W-1:0]  func;
    logic [brf_pkg::DATA_W-1:0]  data_in;

    modport source (output valid, output func, output data_in, input ready);
    modport sink   (input valid, input func, input data_in, output ready);
endinterface

// File: rtl/core/brf_out_if.sv
// result channel of the byte ring fifo: valid/ready plus result fields
// depends on brf_pkg for field widths
interface brf_out_if;
    logic                        valid;
    logic                        ready;
    logic [brf_pkg::DATA_W-1:0]  data_out;
    logic                        done_res;
    logic [brf_pkg::CNT_W-1:0]   fill_count;
    logic [brf_pkg::CNT_W-1:0]   high_water;
    logic [brf_pkg::PCT_W-1:0]   fill_percent;

    modport source (output valid, output data_out, output done_res, output fill_count,
                    output high_water, output fill_percent, input ready);
    modport sink   (input valid, input data_out, input done_res, input fill_count,
                    input high_water, input fill_percent, output ready);
endinterface

// File: rtl/core/byte_ring_fifo_with_fill_stats_unit.sv
// byte ring fifo with fill count, high-water mark and fill percentage
// a request runs through execute, multiply, seven-step restoring divide of count*100/length,
// then finish, which waits for a free output register; only then is a new request taken
// reset: read pointer, count, peak and control cleared, write pointer at length minus one,
// length register set to 4096; the byte store holds undefined data until written
// depends on brf_pkg, brf_in_if, brf_out_if and the assertion macro header
`include "byte_ring_fifo_with_fill_stats_unit_macros.svh"

module byte_ring_fifo_with_fill_stats_unit #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [brf_pkg::LEN_W-1:0]   cfg_wdata,
    brf_in_if.sink                      in_ch,
    brf_out_if.source                   out_ch
);

    // address width of the byte store
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    // largest effective length: store depth, bounded by the 13-bit register
    localparam int LEN_CLAMP = (STORE_DEPTH > brf_pkg::LEN_MAX) ? brf_pkg::LEN_MAX
                                                               : STORE_DEPTH;
    localparam int RST_EFF = (brf_pkg::LEN_RST > LEN_CLAMP) ? LEN_CLAMP : brf_pkg::LEN_RST;
    localparam int PCT_LO  = brf_pkg::DIV_STEPS;

    // ---------------------------------------------------------------------
    // state
    // ---------------------------------------------------------------------
    brf_pkg::state_t                 state_reg, state_next;

    logic [brf_pkg::LEN_W-1:0]       buf_len_reg;
    logic [AW-1:0]                   wr_ptr_reg;
    logic [AW-1:0]                   rd_ptr_reg;
    logic [brf_pkg::CNT_W-1:0]       held_reg;
    logic [brf_pkg::CNT_W-1:0]       peak_reg;

    // captured request (payload, no reset)
    logic [brf_pkg::FUNC_W-1:0]      func_reg;
    logic [brf_pkg::DATA_W-1:0]      din_reg;

    // byte store, one write and one registered read port
    logic [brf_pkg::DATA_W-1:0]      mem [STORE_DEPTH];
    logic [brf_pkg::DATA_W-1:0]      mem_rd_reg;

    // per-request working registers
    logic [brf_pkg::DATA_W-1:0]      dout_reg;
    logic                            done_reg;
    logic [brf_pkg::PROD_W-1:0]      prod_reg;
    logic [brf_pkg::REM_W-1:0]       rem_reg;
    logic [brf_pkg::PCT_W-1:0]       quo_reg;
    logic                            sat_reg;
    logic [brf_pkg::STEP_W-1:0]      step_reg;

    // output register, decouples the result side
    logic                            out_valid_reg;
    logic [brf_pkg::DATA_W-1:0]      out_data_reg;
    logic                            out_done_reg;
    logic [brf_pkg::CNT_W-1:0]       out_fill_reg;
    logic [brf_pkg::CNT_W-1:0]       out_high_reg;
    logic [brf_pkg::PCT_W-1:0]       out_pct_reg;

    // ---------------------------------------------------------------------
    // combinational helpers
    // ---------------------------------------------------------------------
    logic [brf_pkg::LEN_W-1:0]       eff_len;
    logic [AW:0]                     wr_inc;
    logic [AW:0]                     rd_inc;
    logic [AW-1:0]                   wr_adv;
    logic [AW-1:0]                   rd_adv;
    logic [AW-1:0]                   clr_wr_ptr;
    logic [brf_pkg::CMP_W-1:0]       eff_len_m1;
    logic                            is_push;
    logic                            is_pop;
    logic                            is_clear;
    logic                            push_ok;
    logic                            pop_ok;
    logic [brf_pkg::CNT_W-1:0]       held_inc;
    logic [brf_pkg::REM_W-1:0]       rem_src;
    logic [brf_pkg::REM_W-1:0]       rem_sh;
    logic [brf_pkg::REM_W-1:0]       len_ext;
    logic                            div_ge;
    logic                            div_last;
    logic                            out_free;

    // control strobes from the sequencer
    logic                            take_req;
    logic                            do_exec;
    logic                            do_mul;
    logic                            do_div;
    logic                            do_fin;

    // length 0 acts as 1, anything above the store depth acts as the depth
    always_comb
    begin
        if (buf_len_reg == '0)
        begin
            eff_len = brf_pkg::LEN_W'(1);
        end
        else if (brf_pkg::CMP_W'(buf_len_reg) > brf_pkg::CMP_W'(LEN_CLAMP))
        begin
            eff_len = brf_pkg::LEN_W'(LEN_CLAMP);
        end
        else
        begin
            eff_len = buf_len_reg;
        end
    end

    // pointer advance wraps to slot 0 once it reaches or passes the length
    assign wr_inc     = {1'b0, wr_ptr_reg} + (AW+1)'(1);
    assign rd_inc     = {1'b0, rd_ptr_reg} + (AW+1)'(1);
    assign wr_adv     = (brf_pkg::CMP_W'(wr_inc) >= brf_pkg::CMP_W'(eff_len)) ? '0
                                                                         : wr_inc[AW-1:0];
    assign rd_adv     = (brf_pkg::CMP_W'(rd_inc) >= brf_pkg::CMP_W'(eff_len)) ? '0
                                                                         : rd_inc[AW-1:0];
    assign eff_len_m1 = brf_pkg::CMP_W'(eff_len) - brf_pkg::CMP_W'(1);
    assign clr_wr_ptr = eff_len_m1[AW-1:0];

    assign is_push  = (func_reg == brf_pkg::FUNC_PUSH);
    assign is_pop   = (func_reg == brf_pkg::FUNC_POP);
    assign is_clear = (func_reg == brf_pkg::FUNC_CLEAR);
    assign push_ok  = is_push && (held_reg < eff_len);
    assign pop_ok   = is_pop && (held_reg != '0);
    assign held_inc = held_reg + brf_pkg::CNT_W'(1);

    // restoring divide step: first step seeds the remainder from the product top
    assign rem_src  = (step_reg == '0) ? {1'b0, prod_reg[brf_pkg::PROD_W-1:PCT_LO]} : rem_reg;
    assign rem_sh   = {rem_src[brf_pkg::REM_W-2:0], prod_reg[PCT_LO-1]};
    assign len_ext  = brf_pkg::REM_W'(eff_len);
    assign div_ge   = (rem_sh >= len_ext);
    assign div_last = (step_reg == brf_pkg::STEP_W'(brf_pkg::DIV_STEPS - 1));

    // output register can take a new result when empty or being drained
    assign out_free = !out_valid_reg || out_ch.ready;

    // ---------------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brf_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = brf_pkg::ST_EXEC;
                end
            end
            brf_pkg::ST_EXEC:
            begin
                state_next = brf_pkg::ST_MUL;
            end
            brf_pkg::ST_MUL:
            begin
                state_next = brf_pkg::ST_DIV;
            end
            brf_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = brf_pkg::ST_FIN;
                end
            end
            brf_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = brf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brf_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // sequencer: outputs
    // ---------------------------------------------------------------------
    always_comb
    begin
        take_req = 1'b0;
        do_exec  = 1'b0;
        do_mul   = 1'b0;
        do_div   = 1'b0;
        do_fin   = 1'b0;
        unique case (state_reg)
            brf_pkg::ST_IDLE: take_req = in_ch.valid;
            brf_pkg::ST_EXEC: do_exec  = 1'b1;
            brf_pkg::ST_MUL:  do_mul   = 1'b1;
            brf_pkg::ST_DIV:  do_div   = 1'b1;
            brf_pkg::ST_FIN:  do_fin   = out_free;
            default:          take_req = 1'b0;
        endcase
    end

    assign in_ch.ready = (state_reg == brf_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_len_reg <= brf_pkg::LEN_W'(brf_pkg::LEN_RST);
        end
        else if (cfg_we)
        begin
            buf_len_reg <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------------
    // request capture
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            func_reg <= in_ch.func;
            din_reg  <= in_ch.data_in;
        end
    end

    // ---------------------------------------------------------------------
    // byte store: read every cycle at the read pointer, so the byte at the
    // head is ready in the execute cycle; a write lands before the next
    // request is taken, so reads never overlap a pending write
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (do_exec && push_ok)
        begin
            mem[wr_adv] <= din_reg;
        end
        mem_rd_reg <= mem[rd_ptr_reg];
    end

    // ---------------------------------------------------------------------
    // pointers, count and high-water mark, updated in the execute cycle
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= AW'(RST_EFF - 1);
            rd_ptr_reg <= '0;
            held_reg   <= '0;
            peak_reg   <= '0;
        end
        else if (do_exec)
        begin
            // refused push or pop and status queries leave everything as is
            if (push_ok)
            begin
                wr_ptr_reg <= wr_adv;
                held_reg   <= held_inc;
                if (held_inc > peak_reg)
                begin
                    peak_reg <= held_inc;
                end
            end
            else if (pop_ok)
            begin
                rd_ptr_reg <= rd_adv;
                held_reg   <= held_reg - brf_pkg::CNT_W'(1);
            end
            else if (is_clear)
            begin
                wr_ptr_reg <= clr_wr_ptr;
                rd_ptr_reg <= '0;
                held_reg   <= '0;
                peak_reg   <= '0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // result datapath: popped byte, then count*100, then the divide
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (do_exec)
        begin
            done_reg <= push_ok || pop_ok;
            dout_reg <= pop_ok ? mem_rd_reg : '0;
        end
        if (do_mul)
        begin
            prod_reg <= brf_pkg::PROD_W'(held_reg) * brf_pkg::PROD_W'(brf_pkg::PCT_SCALE);
            // count at or above the length reads as a full buffer
            sat_reg  <= (held_reg >= eff_len);
            quo_reg  <= '0;
            step_reg <= '0;
        end
        if (do_div)
        begin
            prod_reg <= prod_reg << 1;
            rem_reg  <= div_ge ? (rem_sh - len_ext) : rem_sh;
            quo_reg  <= {quo_reg[brf_pkg::PCT_W-2:0], div_ge};
            step_reg <= step_reg + brf_pkg::STEP_W'(1);
        end
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_fin)
        begin
            out_data_reg <= dout_reg;
            out_done_reg <= done_reg;
            out_fill_reg <= held_reg;
            out_high_reg <= peak_reg;
            out_pct_reg  <= sat_reg ? brf_pkg::PCT_W'(brf_pkg::PCT_SCALE) : quo_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.data_out     = out_data_reg;
    assign out_ch.done_res     = out_done_reg;
    assign out_ch.fill_count   = out_fill_reg;
    assign out_ch.high_water   = out_high_reg;
    assign out_ch.fill_percent = out_pct_reg;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    `BRF_ASSERT_IMP(a_peak_covers_count, clk, rst_n, 1'b1, held_reg <= peak_reg, "count above high-water mark")
    `BRF_ASSERT_IMP(a_pct_in_range, clk, rst_n, do_fin, (sat_reg || (quo_reg < brf_pkg::PCT_W'(brf_pkg::PCT_SCALE))), "percentage out of range")
    `BRF_ASSERT_NXT(a_push_counts, clk, rst_n, do_exec && push_ok, held_reg == $past(held_reg) + brf_pkg::CNT_W'(1), "push did not raise count")

endmodule

// File: tb/tb_byte_ring_fifo_with_fill_stats_unit.sv
// testbench for the byte ring fifo with fill statistics: directed and random requests,
// every reply checked against a behavioral model of the store, the count and the statistics
// depends on brf_pkg, brf_in_if, brf_out_if and byte_ring_fifo_with_fill_stats_unit
module tb_byte_ring_fifo_with_fill_stats_unit;

    localparam int STORE_DEPTH   = 4096;
    localparam int SETTLE_CYCLES = 4;      // quiet time before a length write
    localparam int DRAIN_CYCLES  = 16;     // idle time after the last reply before the verdict
    localparam int HOLD_CYCLES   = 250;    // long receiver hold-off, forces input stall
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 88;
    localparam int MAX_REPORTS   = 10;

    // one reply of the block, in port order
    typedef struct packed {
        logic [brf_pkg::DATA_W-1:0] data_out;
        logic                       done_res;
        logic [brf_pkg::CNT_W-1:0]  fill_count;
        logic [brf_pkg::CNT_W-1:0]  high_water;
        logic [brf_pkg::PCT_W-1:0]  fill_percent;
    } fifo_reply_t;

    // fifo model plus the queue of replies it predicts
    class fifo_reply_board;
        logic [brf_pkg::DATA_W-1:0] store_bytes [STORE_DEPTH];
        bit                         written [STORE_DEPTH];
        int unsigned                wr_slot;
        int unsigned                rd_slot;
        int unsigned                held;
        int unsigned                peak;
        logic [brf_pkg::LEN_W-1:0]  length_reg;
        fifo_reply_t                pending_replies [$];
        int unsigned                mismatches;

        function new();
            foreach (store_bytes[i])
            begin
                store_bytes[i] = '0;
                written[i]     = 1'b0;
            end
            length_reg = brf_pkg::LEN_W'(brf_pkg::LEN_RST);
            mismatches = 0;
            clear_state();
        endfunction

        // out-of-range lengths: zero acts as one, above the store acts as the store
        function int unsigned active_length();
            if (length_reg == 0)
                return 1;
            if (length_reg > STORE_DEPTH)
                return STORE_DEPTH;
            return length_reg;
        endfunction

        function int unsigned next_slot(int unsigned slot, int unsigned len);
            return (slot + 1 >= len) ? 0 : slot + 1;
        endfunction

        function void clear_state();
            held    = 0;
            peak    = 0;
            wr_slot = active_length() - 1;
            rd_slot = 0;
        endfunction

        // length register write; pointers and count are kept
        function void set_length(logic [brf_pkg::LEN_W-1:0] value);
            length_reg = value;
        endfunction

        // a pop now would read a slot that no push has reached yet
        function bit pop_reads_unwritten();
            return (held > 0) && !written[rd_slot % STORE_DEPTH];
        endfunction

        function void apply_fifo_op(brf_pkg::func_t op, logic [brf_pkg::DATA_W-1:0] byte_in);
            int unsigned len;
            int unsigned pct;
            fifo_reply_t r;
            len = active_length();
            r   = '0;
            case (op)
                brf_pkg::FUNC_PUSH:
                    if (held < len)
                    begin
                        wr_slot = next_slot(wr_slot, len);
                        store_bytes[wr_slot % STORE_DEPTH] = byte_in;
                        written[wr_slot % STORE_DEPTH]     = 1'b1;
                        held++;
                        if (held > peak)
                            peak = held;
                        r.done_res = 1'b1;
                    end
                brf_pkg::FUNC_POP:
                    if (held > 0)
                    begin
                        r.data_out = store_bytes[rd_slot % STORE_DEPTH];
                        rd_slot    = next_slot(rd_slot, len);
                        held--;
                        r.done_res = 1'b1;
                    end
                brf_pkg::FUNC_CLEAR:
                    clear_state();
                default:
                    ;
            endcase
            pct = (held * brf_pkg::PCT_SCALE) / len;
            if (pct > brf_pkg::PCT_SCALE)
                pct = brf_pkg::PCT_SCALE;
            r.fill_count   = brf_pkg::CNT_W'(held);
            r.high_water   = brf_pkg::CNT_W'(peak);
            r.fill_percent = brf_pkg::PCT_W'(pct);
            pending_replies.push_back(r);
        endfunction

        function void check_reply(fifo_reply_t got);
            fifo_reply_t want;
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("reply with none outstanding: data_out %0d done_res %0d count %0d",
                             got.data_out, got.done_res, got.fill_count);
                return;
            end
            want = pending_replies.pop_front();
            if (got.data_out !== want.data_out || got.done_res !== want.done_res ||
                got.fill_count !== want.fill_count || got.high_water !== want.high_water ||
                got.fill_percent !== want.fill_percent)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"reply mismatch (exp/got): data_out %0d/%0d done_res %0d/%0d ",
                              "fill_count %0d/%0d high_water %0d/%0d fill_percent %0d/%0d"},
                             want.data_out, got.data_out, want.done_res, got.done_res,
                             want.fill_count, got.fill_count, want.high_water, got.high_water,
                             want.fill_percent, got.fill_percent);
            end
        endfunction

        function int unsigned outstanding();
            return pending_replies.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [brf_pkg::LEN_W-1:0] cfg_wdata;

    brf_in_if  req_ch ();
    brf_out_if res_ch ();

    fifo_reply_board board;

    // idling controls, written by the stimulus process only
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned holds_asked    = 0;

    byte_ring_fifo_with_fill_stats_unit #(
        .STORE_DEPTH (STORE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (req_ch),
        .out_ch    (res_ch)
    );

    // 2 time unit clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #2000000;
        $display("[byte_ring_fifo_with_fill_stats_unit] ERROR");
        $finish;
    end

    // result side: checks every accepted reply, then picks ready for the next cycle
    initial
    begin : reply_sink
        fifo_reply_t got;
        int unsigned hold_left;
        int unsigned holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            // values seen here are the ones sampled at this edge
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                got.data_out     = res_ch.data_out;
                got.done_res     = res_ch.done_res;
                got.fill_count   = res_ch.fill_count;
                got.high_water   = res_ch.high_water;
                got.fill_percent = res_ch.fill_percent;
                board.check_reply(got);
            end
            // a new hold-off request restarts the count
            if (holds_seen != holds_asked)
            begin
                holds_seen = holds_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // offer one request and wait for its handshake; valid stays high into the next
    // request when no gap is chosen, so it is never lowered and raised in one step
    task automatic send_req(brf_pkg::func_t op, logic [brf_pkg::DATA_W-1:0] byte_in);
        brf_pkg::func_t req_op;
        req_op = op;
        // a pop that would reach a never-written slot goes out as a status query
        if (req_op == brf_pkg::FUNC_POP && board.pop_reads_unwritten())
            req_op = brf_pkg::FUNC_STATUS;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.func    <= req_op;
        req_ch.data_in <= byte_in;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        board.apply_fifo_op(req_op, byte_in);
    endtask

    // length write, only once every reply is back and the block has settled
    task automatic write_length(logic [brf_pkg::LEN_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_length(value);
    endtask

    task automatic set_idle(int mode);
        case (mode)
            1:       begin src_idle_pct = 59; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 59; end
            3:       begin src_idle_pct = 33; sink_stall_pct = 33; end
            default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        endcase
    endtask

    // random mix: a few clears and status queries, push/pop split by push_w percent
    task automatic run_random(int items, int push_w);
        int unsigned    pick;
        brf_pkg::func_t op;
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                op = brf_pkg::FUNC_CLEAR;
            else if (pick < 10)
                op = brf_pkg::FUNC_STATUS;
            else if ($urandom_range(99) < push_w)
                op = brf_pkg::FUNC_PUSH;
            else
                op = brf_pkg::FUNC_POP;
            send_req(op, brf_pkg::DATA_W'($urandom));
        end
    endtask

    // length per random phase: extremes, out-of-range codes and a few random sizes
    function automatic logic [brf_pkg::LEN_W-1:0] phase_length(int p);
        case (p)
            0:       return 13'd4;
            1:       return 13'd1;
            2:       return 13'd16;
            3:       return 13'd0;
            4:       return 13'd8191;
            5:       return 13'd3;
            6:       return 13'd100;
            7:       return brf_pkg::LEN_W'($urandom_range(1, 32));
            8:       return 13'd4096;
            default: return brf_pkg::LEN_W'($urandom_range(1, 8191));
        endcase
    endfunction

    initial
    begin : stimulus
        board = new();
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.func    <= brf_pkg::FUNC_STATUS;
        req_ch.data_in <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // state right after reset, empty pop, byte extremes
        send_req(brf_pkg::FUNC_STATUS, 8'h00);
        send_req(brf_pkg::FUNC_POP,    8'hff);
        send_req(brf_pkg::FUNC_PUSH,   8'h00);
        send_req(brf_pkg::FUNC_PUSH,   8'hff);
        send_req(brf_pkg::FUNC_STATUS, 8'h5a);
        send_req(brf_pkg::FUNC_POP,    8'h00);
        send_req(brf_pkg::FUNC_CLEAR,  8'ha5);
        send_req(brf_pkg::FUNC_POP,    8'h00);

        // fill a 16-slot buffer: full refusal, 100 percent, write wrap
        write_length(13'd16);
        send_req(brf_pkg::FUNC_CLEAR, 8'h00);
        for (int i = 0; i < 16; i++)
            send_req(brf_pkg::FUNC_PUSH, brf_pkg::DATA_W'($urandom));
        send_req(brf_pkg::FUNC_PUSH, 8'h3c);
        send_req(brf_pkg::FUNC_STATUS, 8'h00);
        for (int i = 0; i < 8; i++)
            send_req(brf_pkg::FUNC_POP, 8'h00);
        for (int i = 0; i < 8; i++)
            send_req(brf_pkg::FUNC_PUSH, brf_pkg::DATA_W'($urandom));
        send_req(brf_pkg::FUNC_PUSH, 8'hc3);

        // single-slot buffer
        write_length(13'd1);
        send_req(brf_pkg::FUNC_CLEAR,  8'h00);
        send_req(brf_pkg::FUNC_PUSH,   8'h81);
        send_req(brf_pkg::FUNC_PUSH,   8'h7e);
        send_req(brf_pkg::FUNC_POP,    8'h00);
        send_req(brf_pkg::FUNC_POP,    8'h00);

        // zero length acts as one, written without clear
        write_length(13'd0);
        send_req(brf_pkg::FUNC_PUSH,   8'hff);
        send_req(brf_pkg::FUNC_STATUS, 8'h00);
        send_req(brf_pkg::FUNC_POP,    8'h00);

        // all-ones length acts as the store depth
        write_length(13'd8191);
        send_req(brf_pkg::FUNC_CLEAR,  8'h00);
        for (int i = 0; i < 5; i++)
            send_req(brf_pkg::FUNC_PUSH, brf_pkg::DATA_W'(8'h10 + i));

        // shrink below the count without clear: percent saturates, push refused,
        // pops wrap at the new length
        write_length(13'd3);
        send_req(brf_pkg::FUNC_STATUS, 8'h00);
        send_req(brf_pkg::FUNC_PUSH,   8'hee);
        for (int i = 0; i < 6; i++)
            send_req(brf_pkg::FUNC_POP, 8'h00);
        send_req(brf_pkg::FUNC_CLEAR,  8'h00);

        // random phases, each with its own length, push bias and idling
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_length(phase_length(p));
            // most length changes are followed by a clear, some keep the pointers
            if ($urandom_range(2) != 0)
                send_req(brf_pkg::FUNC_CLEAR, brf_pkg::DATA_W'($urandom));
            set_idle(p % 4);
            // long receiver hold-off while requests keep coming
            if (p == 0 || p == 4)
                holds_asked++;
            run_random(PHASE_ITEMS, (p % 3 == 0) ? 50 : ((p % 3 == 1) ? 75 : 30));
        end

        // drain
        req_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("[byte_ring_fifo_with_fill_stats_unit] OK");
        else
            $display("[byte_ring_fifo_with_fill_stats_unit] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/brf_pkg.sv
rtl/core/brf_in_if.sv
rtl/core/brf_out_if.sv
rtl/core/byte_ring_fifo_with_fill_stats_unit.sv
tb/tb_byte_ring_fifo_with_fill_stats_unit.sv
